// ===== hdl/percent_decode_stream_assert.svh =====
// Assertion macros used by the percent decoder queue.
`ifndef PERCENT_DECODE_STREAM_ASSERT_SVH
`define PERCENT_DECODE_STREAM_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PDS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("percent decoder assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("percent decoder assertion failed");

`endif

// ===== hdl/pds_pkg.sv =====
// Shared types, constants and helper functions of the percent decoder.
package pds_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam int HEX_RADIX = 16;
    localparam int NIB_W = $clog2(HEX_RADIX);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_PCT = 2'd1;
    localparam logic [1:0] PHASE_DIGIT = 2'd2;

    typedef struct packed {
        logic [1:0] cnt;
        logic [2:0][7:0] bytes;
        logic last;
    } group_t;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) ||
                 (c >= 8'h41 && c <= 8'h46) ||
                 (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [NIB_W-1:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h57;
        end
        hex_val = v[NIB_W-1:0];
    endfunction

endpackage

// ===== hdl/percent_decode_stream.sv =====
// Top level of the streaming URI percent decoder.
//
//   channel | direction | fields             | handshake
//   input   | in        | in_byte, in_last   | in_valid / in_ready
//   output  | out       | out_byte, out_last | out_valid / out_ready
//
// Each input request is classified combinationally, and one byte is taken per cycle
// while the queue is not full; a group of two or three bytes is sent by the back end
// one byte per cycle while out_ready is high.
// A four-entry queue of byte groups separates the two sides, so input is
// accepted while output stalls until the queue is full.
// Reset is asynchronous and active low and returns the block to no escape pending.
module percent_decode_stream
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic            push;
    logic            full;
    logic            pop;
    logic            q_valid;
    pds_pkg::group_t push_group;
    pds_pkg::group_t head;

    pds_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .q_full     (full),
        .push       (push),
        .push_group (push_group)
    );

    pds_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .full       (full),
        .pop        (pop),
        .q_valid    (q_valid),
        .head       (head)
    );

    pds_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

// ===== hdl/pds_front.sv =====
// Front end: tracks escape phase and turns each input byte into a group of 0-3 output bytes.
module pds_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  logic              q_full,
    output logic              push,
    output pds_pkg::group_t   push_group
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic [1:0] pre_cnt;
    logic [7:0] pre0;
    logic [7:0] pre1;
    logic       do_fresh;
    logic       fresh_put;
    logic       fire;
    logic       hex;

    assign in_ready = !q_full;
    assign fire = in_valid && in_ready;
    assign hex = pds_pkg::is_hex(in_byte);

    always_comb
    begin
        phase_next = pds_pkg::PHASE_IDLE;
        held_next = held_reg;
        pre_cnt = 2'd0;
        pre0 = pds_pkg::PCT_CHAR;
        pre1 = in_byte;
        do_fresh = 1'b0;
        unique case (phase_reg)
            pds_pkg::PHASE_PCT:
            begin
                if (hex)
                begin
                    if (in_last)
                    begin
                        pre_cnt = 2'd2;
                    end
                    else
                    begin
                        held_next = in_byte;
                        phase_next = pds_pkg::PHASE_DIGIT;
                    end
                end
                else
                begin
                    pre_cnt = 2'd1;
                    do_fresh = 1'b1;
                end
            end
            pds_pkg::PHASE_DIGIT:
            begin
                if (hex)
                begin
                    pre_cnt = 2'd1;
                    pre0 = {pds_pkg::hex_val(held_reg), pds_pkg::hex_val(in_byte)};
                end
                else
                begin
                    pre_cnt = 2'd2;
                    pre1 = held_reg;
                    do_fresh = 1'b1;
                end
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase
        fresh_put = do_fresh && !(in_byte == pds_pkg::PCT_CHAR && !in_last);
        if (do_fresh && !fresh_put)
        begin
            phase_next = pds_pkg::PHASE_PCT;
        end
    end

    always_comb
    begin
        push_group.cnt = pre_cnt + {1'b0, fresh_put};
        push_group.last = in_last;
        push_group.bytes[0] = (pre_cnt == 2'd0) ? in_byte : pre0;
        push_group.bytes[1] = (pre_cnt == 2'd1) ? in_byte : pre1;
        push_group.bytes[2] = in_byte;
    end

    assign push = fire && (push_group.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pds_pkg::PHASE_IDLE;
            held_reg <= 8'h00;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            held_reg <= held_next;
        end
    end

endmodule

// ===== hdl/pds_queue.sv =====
// Short queue of byte groups between the front end and the back end.
`include "percent_decode_stream_assert.svh"

module pds_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pds_pkg::group_t   push_group,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output pds_pkg::group_t   head
);

    pds_pkg::group_t entry_reg [pds_pkg::QDEPTH];
    logic [pds_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [pds_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [pds_pkg::QCNT_W-1:0] count_reg;
    logic [pds_pkg::QCNT_W-1:0] count_next;

    assign full = (count_reg == pds_pkg::QCNT_W'(pds_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + pds_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - pds_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + pds_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + pds_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    `PDS_ASSERT_NOW(a_no_push_full, push, !full)
    `PDS_ASSERT_NOW(a_no_pop_empty, pop, q_valid)
    `PDS_ASSERT_NOW(a_no_empty_group, push, push_group.cnt != 2'd0)
    `PDS_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + pds_pkg::QCNT_W'(1))

endmodule

// ===== hdl/pds_back.sv =====
// Back end: sends the bytes of each queued group one per cycle while out_ready is high.
module pds_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  pds_pkg::group_t   head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              out_last
);

    pds_pkg::group_t cur_reg;
    logic            busy_reg;
    logic [1:0]      idx_reg;
    logic            final_beat;
    logic            done;

    assign out_valid = busy_reg;
    assign final_beat = (idx_reg == cur_reg.cnt - 2'd1);
    assign done = busy_reg && out_ready && final_beat;
    assign pop = q_valid && (!busy_reg || done);
    assign out_last = cur_reg.last && final_beat;

    always_comb
    begin
        case (idx_reg)
            2'd0: out_byte = cur_reg.bytes[0];
            2'd1: out_byte = cur_reg.bytes[1];
            default: out_byte = cur_reg.bytes[2];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg <= 2'd0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg <= 2'd0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
            idx_reg <= 2'd0;
        end
        else if (busy_reg && out_ready)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

// ===== tb/percent_decode_stream_tb.sv =====
// Self-checking testbench for the streaming URI percent decoder.
module percent_decode_stream_tb;

    class pct_decode_checker;
        logic [1:0] phase;
        logic [7:0] held_digit;
        logic [7:0] decoded_bytes_q[$];
        logic       decoded_last_q[$];
        int         errors;

        function new();
            phase = pds_pkg::PHASE_IDLE;
            held_digit = 8'h00;
            errors = 0;
        endfunction

        // Returns the digit flag in bit 4 and the nibble value below it.
        function logic [4:0] digit_lookup(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39)
            begin
                return {1'b1, c[3:0]};
            end
            if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            begin
                return {1'b1, 4'(c[3:0] + 4'd9)};
            end
            return 5'd0;
        endfunction

        function void push_decoded(logic [7:0] b, logic l);
            decoded_bytes_q.push_back(b);
            decoded_last_q.push_back(l);
        endfunction

        function void take_plain(logic [7:0] b, logic l);
            if (b == pds_pkg::PCT_CHAR && !l)
            begin
                phase = pds_pkg::PHASE_PCT;
            end
            else
            begin
                push_decoded(b, l);
                phase = pds_pkg::PHASE_IDLE;
            end
        endfunction

        function void note_request(logic [7:0] b, logic l);
            logic [4:0] d;
            logic [4:0] h;
            d = digit_lookup(b);
            case (phase)
                pds_pkg::PHASE_PCT:
                begin
                    if (d[4] && l)
                    begin
                        push_decoded(pds_pkg::PCT_CHAR, 1'b0);
                        push_decoded(b, 1'b1);
                        phase = pds_pkg::PHASE_IDLE;
                    end
                    else if (d[4])
                    begin
                        held_digit = b;
                        phase = pds_pkg::PHASE_DIGIT;
                    end
                    else
                    begin
                        push_decoded(pds_pkg::PCT_CHAR, 1'b0);
                        take_plain(b, l);
                    end
                end
                pds_pkg::PHASE_DIGIT:
                begin
                    if (d[4])
                    begin
                        h = digit_lookup(held_digit);
                        push_decoded({h[3:0], d[3:0]}, l);
                        phase = pds_pkg::PHASE_IDLE;
                    end
                    else
                    begin
                        push_decoded(pds_pkg::PCT_CHAR, 1'b0);
                        push_decoded(held_digit, 1'b0);
                        take_plain(b, l);
                    end
                end
                default:
                begin
                    take_plain(b, l);
                end
            endcase
        endfunction

        function int pending();
            return decoded_bytes_q.size();
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [7:0] b, logic l);
            logic [7:0] want_byte;
            logic       want_last;
            if (decoded_bytes_q.size() == 0)
            begin
                report($sformatf("unexpected output byte %02h last %0b", b, l));
                return;
            end
            want_byte = decoded_bytes_q.pop_front();
            want_last = decoded_last_q.pop_front();
            if (b !== want_byte)
            begin
                report($sformatf("out_byte %02h, expected %02h", b, want_byte));
            end
            if (l !== want_last)
            begin
                report($sformatf("out_last %0b, expected %0b", l, want_last));
            end
        endtask

        task drain_check();
            if (decoded_bytes_q.size() != 0)
            begin
                report($sformatf("%0d expected bytes never arrived", decoded_bytes_q.size()));
            end
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;

    pct_decode_checker checker_h = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int requests_sent = 0;

    percent_decode_stream DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_byte(in_byte),
        .in_last(in_last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_byte(out_byte),
        .out_last(out_last)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #(8 * 400000);
        $display("Regression FAIL");
        $finish;
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else
        begin
            out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            checker_h.check_result(out_byte, out_last);
        end
    end

    // Entered and left just after a falling edge.
    task automatic send_request(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_byte = b;
        in_last = l;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        checker_h.note_request(b, l);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++)
        begin
            send_request(t[i], i == t.len() - 1);
        end
    endtask

    function automatic logic [7:0] random_hex_char();
        string digits;
        digits = "0123456789ABCDEFabcdef";
        return digits[$urandom_range(21)];
    endfunction

    task automatic send_random_string();
        logic [7:0] s[$];
        int n;
        int pick;
        n = $urandom_range(1, 10);
        while (s.size() < n)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                s.push_back(pds_pkg::PCT_CHAR);
                s.push_back(random_hex_char());
                s.push_back(random_hex_char());
            end
            else if (pick < 58)
            begin
                s.push_back(pds_pkg::PCT_CHAR);
                if ($urandom_range(1))
                begin
                    s.push_back(random_hex_char());
                end
            end
            else if (pick < 80)
            begin
                s.push_back(8'($urandom_range(32, 126)));
            end
            else
            begin
                s.push_back(8'($urandom_range(255)));
            end
        end
        foreach (s[i])
        begin
            send_request(s[i], i == s.size() - 1);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct = 27;
        recv_idle_pct = 68;
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b1);
        send_text("%41%6f");
        send_text("%00");
        send_text("%%fF");
        send_text("%4g");
        send_text("%a");
        send_text("%");
        send_request(pds_pkg::PCT_CHAR, 1'b0);
        send_request(8'h80, 1'b1);
        while (requests_sent < 110)
        begin
            send_random_string();
        end

        send_idle_pct = 68;
        recv_idle_pct = 27;
        while (requests_sent < 220)
        begin
            send_random_string();
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 150;
        while (requests_sent < 330)
        begin
            send_random_string();
        end
        in_valid = 1'b0;

        while (checker_h.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
        checker_h.drain_check();
        if (checker_h.errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/pds_pkg.sv
hdl/pds_front.sv
hdl/pds_queue.sv
hdl/pds_back.sv
hdl/percent_decode_stream.sv
tb/percent_decode_stream_tb.sv
